// ===== rtl/core/bbwm_pkg.sv =====
// ----------------------------------------------------------------------------
// bbwm_pkg
// Shared constants and types of the box blur window mean block.
// ----------------------------------------------------------------------------
package bbwm_pkg;

   // image geometry
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int COORD_W    = 8;
   localparam int DIM_W      = 9;
   localparam int RAD_W      = 8;
   localparam int PIX_W      = 8;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int ADDR_W     = COL_W + ROW_W;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

   // accumulator and divider widths
   localparam int CNT_W = ADDR_W + 1;
   localparam int SUM_W = PIX_W + ADDR_W;
   localparam int DVD_W = SUM_W + 2;
   localparam int DVS_W = CNT_W + 1;
   localparam int QUO_W = PIX_W;
   localparam int STEP_W = $clog2(QUO_W);

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_X     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_Y     = 2'd3;

   // request kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_BLUR = 1'b1;

   // divider command and result
   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/core/box_blur_window_mean.sv =====
// ----------------------------------------------------------------------------
// box_blur_window_mean: a load leaves the block ready, next item may follow at once
// a blur query holds the block while it scans the clipped window, one store read per pixel
// scan is followed by a restoring divide; not ready during a query
// a query whose clipped window is empty skips the scan and divide; a held result adds its wait
// sync reset clears control and sets configuration defaults; pixel store is undefined until loaded
// ----------------------------------------------------------------------------
module box_blur_window_mean (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [bbwm_pkg::COORD_W-1:0]      req_pos_x,
   input  logic [bbwm_pkg::COORD_W-1:0]      req_pos_y,
   input  logic [bbwm_pkg::PIX_W-1:0]        req_pixel_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bbwm_pkg::PIX_W-1:0]        rsp_blurred_value,
   input  logic                              csr_we,
   input  logic [bbwm_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  logic [bbwm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bbwm_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      DRAIN,
      DIV_LOAD,
      DIV_WAIT,
      FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic [RAD_W-1:0]   rad_x_ff, rad_x_in;
   logic [RAD_W-1:0]   rad_y_ff, rad_y_in;
   logic [COORD_W-1:0] x0_ff, x0_in, x1_ff, x1_in;
   logic [COORD_W-1:0] y0_ff, y0_in, y1_ff, y1_in;
   logic [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic               rd_pend_ff, rd_pend_in;
   logic               empty_ff, empty_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]   value_ff, value_in;

   logic               req_xfer;
   logic [DIM_W-1:0]   w_eff, h_eff;
   logic [COORD_W-1:0] lo_x, lo_y;
   logic [DIM_W:0]     hi_x_raw, hi_y_raw, w_m1, h_m1;
   logic [DIM_W:0]     hi_x, hi_y;
   logic               empty_x, empty_y;
   logic               in_image;
   logic               store_wr;
   logic [PIX_W-1:0]   rd_data;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   assign req_ready = (state_ff == IDLE);
   assign req_xfer  = req_valid && req_ready;

   // effective image size, saturated to the store
   assign w_eff = (width_ff  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : width_ff;
   assign h_eff = (height_ff > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_ff;

   // window clipping
   assign lo_x     = (req_pos_x > rad_x_ff) ? req_pos_x - rad_x_ff : '0;
   assign lo_y     = (req_pos_y > rad_y_ff) ? req_pos_y - rad_y_ff : '0;
   assign hi_x_raw = (DIM_W+1)'(req_pos_x) + (DIM_W+1)'(rad_x_ff);
   assign hi_y_raw = (DIM_W+1)'(req_pos_y) + (DIM_W+1)'(rad_y_ff);
   assign w_m1     = (DIM_W+1)'(w_eff) - 1'b1;
   assign h_m1     = (DIM_W+1)'(h_eff) - 1'b1;
   assign hi_x     = (hi_x_raw > w_m1) ? w_m1 : hi_x_raw;
   assign hi_y     = (hi_y_raw > h_m1) ? h_m1 : hi_y_raw;
   assign empty_x  = (w_eff == '0) || ((DIM_W+1)'(lo_x) > hi_x);
   assign empty_y  = (h_eff == '0) || ((DIM_W+1)'(lo_y) > hi_y);

   // load path into the pixel store
   assign in_image = (DIM_W'(req_pos_x) < w_eff) && (DIM_W'(req_pos_y) < h_eff);
   assign store_wr = req_xfer && (req_kind == KIND_LOAD) && in_image;

   bbwm_store u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr ({req_pos_y[ROW_W-1:0], req_pos_x[COL_W-1:0]}),
      .wr_data (req_pixel_in),
      .rd_addr ({cy_ff[ROW_W-1:0], cx_ff[COL_W-1:0]}),
      .rd_data (rd_data)
   );

   // rounded mean as (2*sum + count) / (2*count)
   assign div_req.start    = (state_ff == DIV_LOAD);
   assign div_req.dividend = {1'b0, sum_ff, 1'b0} + DVD_W'(count_ff);
   assign div_req.divisor  = {count_ff, 1'b0};

   bbwm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      rad_x_in     = rad_x_ff;
      rad_y_in     = rad_y_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      empty_in     = empty_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      value_in     = value_ff;
      rd_pend_in   = (state_ff == SCAN);

      // configuration writes
      if (csr_we) begin
         unique case (csr_addr)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            CSR_RADIUS_X:     rad_x_in  = csr_wdata[RAD_W-1:0];
            CSR_RADIUS_Y:     rad_y_in  = csr_wdata[RAD_W-1:0];
            default: ;
         endcase
      end

      // accumulate pixels returned by the store
      if (rd_pend_ff) begin
         sum_in   = sum_ff + SUM_W'(rd_data);
         count_in = count_ff + 1'b1;
      end

      // result transfer frees the output register
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         IDLE: begin
            if (req_xfer && (req_kind == KIND_BLUR)) begin
               x0_in    = lo_x;
               x1_in    = hi_x[COORD_W-1:0];
               y0_in    = lo_y;
               y1_in    = hi_y[COORD_W-1:0];
               cx_in    = lo_x;
               cy_in    = lo_y;
               sum_in   = '0;
               count_in = '0;
               empty_in = empty_x || empty_y;
               state_in = (empty_x || empty_y) ? FINISH : SCAN;
            end
         end
         SCAN: begin
            if (cx_ff == x1_ff) begin
               cx_in = x0_ff;
               if (cy_ff == y1_ff) begin
                  state_in = DRAIN;
               end else begin
                  cy_in = cy_ff + 1'b1;
               end
            end else begin
               cx_in = cx_ff + 1'b1;
            end
         end
         DRAIN:    state_in = DIV_LOAD;
         DIV_LOAD: state_in = DIV_WAIT;
         DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = FINISH;
            end
         end
         FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               value_in     = empty_ff ? '0 : div_rsp.quotient;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      x0_ff    <= x0_in;
      x1_ff    <= x1_in;
      y0_ff    <= y0_in;
      y1_ff    <= y1_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      empty_ff <= empty_in;
      sum_ff   <= sum_in;
      count_ff <= count_in;
      value_ff <= value_in;
      if (reset) begin
         state_ff     <= IDLE;
         width_ff     <= DIM_W'(256);
         height_ff    <= DIM_W'(256);
         rad_x_ff     <= RAD_W'(1);
         rad_y_ff     <= RAD_W'(1);
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rad_x_ff     <= rad_x_in;
         rad_y_ff     <= rad_y_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_blurred_value = value_ff;

   // a blur transfer always leaves idle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_kind == KIND_BLUR)) |=> !req_ready)
      else $error("query accepted but block still ready");

   // scan position stays inside the clipped window
   a_scan_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCAN) |-> (cx_ff >= x0_ff) && (cx_ff <= x1_ff) &&
                             (cy_ff >= y0_ff) && (cy_ff <= y1_ff))
      else $error("scan position outside window");

   // divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == DIV_WAIT))
      else $error("divider done outside wait state");

endmodule

// ===== rtl/core/bbwm_store.sv =====
// ----------------------------------------------------------------------------
// bbwm_store
// Pixel store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bbwm_store (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [bbwm_pkg::ADDR_W-1:0]   wr_addr,
   input  logic [bbwm_pkg::PIX_W-1:0]    wr_data,
   input  logic [bbwm_pkg::ADDR_W-1:0]   rd_addr,
   output logic [bbwm_pkg::PIX_W-1:0]    rd_data
);
   import bbwm_pkg::*;

   logic [PIX_W-1:0] mem_ff [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bbwm_divider.sv =====
// ----------------------------------------------------------------------------
// bbwm_divider
// Restoring divider, one quotient bit per cycle, quotient known below 2^QUO_W.
// ----------------------------------------------------------------------------
module bbwm_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  bbwm_pkg::div_req_type div_req,
   output bbwm_pkg::div_rsp_type div_rsp
);
   import bbwm_pkg::*;

   logic [DVD_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  dsh_ff, dsh_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVD_W-1:0]  diff;
   logic              fits;

   // one trial subtraction per cycle
   assign diff = rem_ff - dsh_ff;
   assign fits = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.dividend;
         dsh_in  = DVD_W'({div_req.divisor, {(QUO_W-1){1'b0}}});
         quo_in  = '0;
         step_in = STEP_W'(QUO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = diff;
         end
         quo_in = {quo_ff[QUO_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
